// ===== sv/ltcdec_pkg.sv =====
`timescale 1ns / 1ps

package ltcdec_pkg;

  typedef enum logic [1:0] {
    LAYOUT_NONE = 2'd0,
    LAYOUT_BBC  = 2'd1,
    LAYOUT_TVE  = 2'd2,
    LAYOUT_MTD  = 2'd3
  } layout_e;

  localparam logic [1:0] DATE_AUTO = 2'd0;

  localparam logic [7:0]  YEAR_PIVOT   = 8'd67;
  localparam logic [11:0] CENTURY_20XX = 12'd2000;
  localparam logic [11:0] CENTURY_19XX = 12'd1900;
  localparam logic [5:0]  FRAMES_24    = 6'd24;
  localparam logic [7:0]  DAY_MAX      = 8'd31;
  localparam logic [7:0]  MONTH_MAX    = 8'd12;
  localparam logic [3:0]  BBC_MONTH_HI = 4'h4;
  localparam logic [3:0]  BBC_DAY_MASK = 4'h3;
  localparam logic [1:0]  TZ_INVALID   = 2'd3;

  typedef struct packed {
    logic [7:0] yy;
    logic [7:0] mo;
    logic [7:0] dd;
    logic [1:0] tz;
    logic       ok;
  } date_t;

  function automatic logic [7:0] digit_pair(input logic [3:0] lo, input logic [3:0] hi);
    return 8'(lo) + (8'(hi) << 3) + (8'(hi) << 1);
  endfunction

  function automatic logic [3:0] user_nib(input logic [63:0] w, input int unsigned grp);
    return w[4 + 8 * grp +: 4];
  endfunction

  function automatic date_t decode_layout(input logic [63:0] w, input layout_e layout);
    date_t      d;
    logic [3:0] u1, u2, u3, u4, u5, u6, u7, u8;
    u1 = user_nib(w, 0);
    u2 = user_nib(w, 1);
    u3 = user_nib(w, 2);
    u4 = user_nib(w, 3);
    u5 = user_nib(w, 4);
    u6 = user_nib(w, 5);
    u7 = user_nib(w, 6);
    u8 = user_nib(w, 7);
    d.tz = 2'd0;
    unique case (layout)
      LAYOUT_BBC: begin
        d.yy = digit_pair(u6, u8);
        d.mo = 8'(u3) + (((u4 & BBC_MONTH_HI) != 4'd0) ? 8'd10 : 8'd0);
        d.dd = digit_pair(u2, u4 & BBC_DAY_MASK);
      end
      LAYOUT_TVE: begin
        d.yy = digit_pair(u6, u7);
        d.mo = digit_pair(u4, u5);
        d.dd = digit_pair(u2, u3);
      end
      default: begin
        d.yy = digit_pair(u2, u1);
        d.mo = digit_pair(u4, u3);
        d.dd = digit_pair(u6, u5);
        d.tz = (u7[1:0] == TZ_INVALID) ? 2'd0 : u7[1:0];
      end
    endcase
    d.ok = (d.dd != 8'd0) && (d.dd <= DAY_MAX) && (d.mo != 8'd0) && (d.mo <= MONTH_MAX);
    return d;
  endfunction

endpackage

// ===== sv/ltcdec_frame_if.sv =====
`timescale 1ns / 1ps

interface ltcdec_frame_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_word;

  modport source (output valid, output frame_word, input ready);
  modport sink (input valid, input frame_word, output ready);
endinterface

// ===== sv/ltcdec_result_if.sv =====
`timescale 1ns / 1ps

interface ltcdec_result_if;
  logic        valid;
  logic        ready;
  logic [5:0]  hours;
  logic [6:0]  minutes;
  logic [6:0]  seconds;
  logic [5:0]  frames;
  logic        drop_frame;
  logic [5:0]  frame_rate;
  logic [1:0]  user_mode;
  logic [1:0]  date_format;
  logic [11:0] year;
  logic [7:0]  month;
  logic [7:0]  day;
  logic [1:0]  tz_hours;

  modport source (
    output valid, hours, minutes, seconds, frames, drop_frame, frame_rate,
    output user_mode, date_format, year, month, day, tz_hours,
    input ready
  );
  modport sink (
    input valid, hours, minutes, seconds, frames, drop_frame, frame_rate,
    input user_mode, date_format, year, month, day, tz_hours,
    output ready
  );
endinterface

// ===== sv/ltc_frame_timecode_date_decoder_top.sv =====
// A frame request is captured in the input register, then in the result register that drives result valid.
// Throughput: one frame request per cycle while the result register is empty or being taken;
// input register then result register, both advancing together at such times.
// Reset (async, active low): pipeline empty, frame tracking cleared, date mode automatic.
`timescale 1ns / 1ps

module ltc_frame_timecode_date_decoder_top
  import ltcdec_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   date_mode_we_i,
  input  logic [1:0]             date_mode_i,
  ltcdec_frame_if.sink           in_if,
  ltcdec_result_if.source        out_if
);

  logic [1:0]  date_mode_q;
  logic        in_valid_q;
  logic [63:0] word_q;
  logic        out_valid_q;
  logic [5:0]  last_frame_q, last_frame_d;
  logic [5:0]  highest_q, highest_d;

  logic [5:0]  hours_q, frames_q, rate_q;
  logic [6:0]  minutes_q, seconds_q;
  logic        drop_q;
  logic [1:0]  user_mode_q, fmt_q, tz_q;
  logic [11:0] year_q;
  logic [7:0]  month_q, day_q;

  logic        advance;
  logic [5:0]  frame_num, hours_c;
  logic [6:0]  minutes_c, seconds_c;
  logic [1:0]  mode_c;
  layout_e     fmt_c;
  date_t       bbc, tve, mtd, sel;
  logic [11:0] year_c;

  assign advance     = !out_valid_q || out_if.ready;
  assign in_if.ready = !in_valid_q || advance;

  assign hours_c   = 6'(word_q[51:48]) + 6'(word_q[57:56]) * 6'd10;
  assign minutes_c = 7'(word_q[35:32]) + 7'(word_q[42:40]) * 7'd10;
  assign seconds_c = 7'(word_q[19:16]) + 7'(word_q[26:24]) * 7'd10;
  assign frame_num = 6'(word_q[3:0]) + 6'(word_q[9:8]) * 6'd10;

  assign bbc = decode_layout(word_q, LAYOUT_BBC);
  assign tve = decode_layout(word_q, LAYOUT_TVE);
  assign mtd = decode_layout(word_q, LAYOUT_MTD);

  always_comb begin
    if (highest_q == FRAMES_24) begin
      mode_c = {word_q[43], word_q[27]};
    end else begin
      mode_c = {word_q[59], word_q[43]};
    end

    if (date_mode_q == DATE_AUTO) begin
      if (bbc.ok) begin
        fmt_c = LAYOUT_BBC;
      end else if (tve.ok) begin
        fmt_c = LAYOUT_TVE;
      end else begin
        fmt_c = LAYOUT_MTD;
      end
    end else begin
      fmt_c = layout_e'(date_mode_q);
    end

    unique case (fmt_c)
      LAYOUT_BBC: sel = bbc;
      LAYOUT_TVE: sel = tve;
      default:    sel = mtd;
    endcase

    year_c = (sel.yy < YEAR_PIVOT) ? CENTURY_20XX + 12'(sel.yy)
                                   : CENTURY_19XX + 12'(sel.yy);

    highest_d = highest_q;
    if (frame_num == 6'd0 && last_frame_q != 6'd0) begin
      highest_d = last_frame_q;
    end
    last_frame_d = frame_num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_mode_q  <= DATE_AUTO;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      last_frame_q <= 6'd0;
      highest_q    <= 6'd0;
    end else begin
      if (date_mode_we_i) begin
        date_mode_q <= date_mode_i;
      end
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (in_valid_q && advance) begin
        last_frame_q <= last_frame_d;
        highest_q    <= highest_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      word_q <= in_if.frame_word;
    end
    if (in_valid_q && advance) begin
      hours_q     <= hours_c;
      minutes_q   <= minutes_c;
      seconds_q   <= seconds_c;
      frames_q    <= frame_num;
      drop_q      <= word_q[10];
      rate_q      <= highest_d + 6'd1;
      user_mode_q <= mode_c;
      if (!mode_c[0]) begin
        fmt_q   <= fmt_c;
        year_q  <= year_c;
        month_q <= sel.mo;
        day_q   <= sel.dd;
        tz_q    <= sel.tz;
      end else begin
        fmt_q   <= LAYOUT_NONE;
        year_q  <= 12'd0;
        month_q <= 8'd0;
        day_q   <= 8'd0;
        tz_q    <= 2'd0;
      end
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.hours       = hours_q;
  assign out_if.minutes     = minutes_q;
  assign out_if.seconds     = seconds_q;
  assign out_if.frames      = frames_q;
  assign out_if.drop_frame  = drop_q;
  assign out_if.frame_rate  = rate_q;
  assign out_if.user_mode   = user_mode_q;
  assign out_if.date_format = fmt_q;
  assign out_if.year        = year_q;
  assign out_if.month       = month_q;
  assign out_if.day         = day_q;
  assign out_if.tz_hours    = tz_q;

endmodule

// ===== sv/ltcdec_checker.sv =====
`timescale 1ns / 1ps

module ltcdec_checker
  import ltcdec_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [5:0]  frame_rate_i,
  input logic [1:0]  user_mode_i,
  input logic [1:0]  date_format_i,
  input logic [11:0] year_i,
  input logic [7:0]  month_i,
  input logic [7:0]  day_i,
  input logic [1:0]  tz_hours_i
);

  // result request held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped before taken");

  // page/line and eight-bit modes carry no date
  a_no_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && user_mode_i[0] |->
      date_format_i == LAYOUT_NONE && year_i == 12'd0 && month_i == 8'd0 &&
      day_i == 8'd0 && tz_hours_i == 2'd0)
    else $error("date fields set outside date mode");

  a_date_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !user_mode_i[0] |->
      date_format_i != LAYOUT_NONE && year_i >= 12'd1967 && year_i <= 12'd2066)
    else $error("date mode without a decoded year");

  a_tz_mtd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && date_format_i != LAYOUT_MTD |-> tz_hours_i == 2'd0)
    else $error("time zone outside MTD layout");

  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_rate_i != 6'd0 && frame_rate_i <= 6'd46)
    else $error("frame rate out of range");

endmodule

bind ltc_frame_timecode_date_decoder_top ltcdec_checker u_ltcdec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .frame_rate_i  (out_if.frame_rate),
  .user_mode_i   (out_if.user_mode),
  .date_format_i (out_if.date_format),
  .year_i        (out_if.year),
  .month_i       (out_if.month),
  .day_i         (out_if.day),
  .tz_hours_i    (out_if.tz_hours)
);

// ===== verif/tb_ltc_frame_timecode_date_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_ltc_frame_timecode_date_decoder_top;
  import ltcdec_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_FRAMES = 130;
  // date mode per random phase, first phase leftmost
  localparam logic [15:0] MODE_PLAN = {LAYOUT_BBC, LAYOUT_TVE, LAYOUT_MTD, DATE_AUTO,
                                       LAYOUT_MTD, LAYOUT_BBC, LAYOUT_TVE, DATE_AUTO};

  typedef struct packed {
    logic [5:0]  hours;
    logic [6:0]  minutes;
    logic [6:0]  seconds;
    logic [5:0]  frames;
    logic        drop_frame;
    logic [5:0]  frame_rate;
    logic [1:0]  user_mode;
    layout_e     date_format;
    logic [11:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [1:0]  tz_hours;
  } tc_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       date_mode_we_i;
  logic [1:0] date_mode_i;

  ltcdec_frame_if  frame_ch ();
  ltcdec_result_if result_ch ();

  ltc_frame_timecode_date_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .date_mode_we_i (date_mode_we_i),
    .date_mode_i    (date_mode_i),
    .in_if          (frame_ch),
    .out_if         (result_ch)
  );

  logic [63:0] frame_queue[$];
  tc_result_t  pending_results[$];
  tc_result_t  want;

  logic [5:0] frame_last;
  logic [5:0] frame_high;
  logic [1:0] date_sel;

  bit calm;
  int gap_left;
  int stall_left;
  int errors;
  int frames_sent;
  int results_seen;
  int mode_writes;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit user_date(input logic [63:0] w, input layout_e lay,
                                   output int yy, output int mo, output int dd,
                                   output int tz);
    int u[1:8];
    int z;
    for (int g = 1; g <= 8; g++) u[g] = int'(w[8 * g - 4 +: 4]);
    tz = 0;
    case (lay)
      LAYOUT_BBC: begin
        yy = u[6] + 10 * u[8];
        mo = u[3] + (((u[4] & BBC_MONTH_HI) != 0) ? 10 : 0);
        dd = u[2] + 10 * (u[4] & BBC_DAY_MASK);
      end
      LAYOUT_TVE: begin
        yy = u[6] + 10 * u[7];
        mo = u[4] + 10 * u[5];
        dd = u[2] + 10 * u[3];
      end
      default: begin
        yy = u[2] + 10 * u[1];
        mo = u[4] + 10 * u[3];
        dd = u[6] + 10 * u[5];
        z  = u[7] & 3;
        tz = (z == TZ_INVALID) ? 0 : z;
      end
    endcase
    return dd >= 1 && dd <= DAY_MAX && mo >= 1 && mo <= MONTH_MAX;
  endfunction

  // updates frame tracking as a side effect
  function automatic tc_result_t decode_frame(input logic [63:0] w);
    tc_result_t r;
    int fr, yy, mo, dd, tz;
    logic f0, f2;
    layout_e lay;
    r  = '0;
    fr = int'(w[3:0]) + 10 * int'(w[9:8]);
    r.hours      = 6'(int'(w[51:48]) + 10 * int'(w[57:56]));
    r.minutes    = 7'(int'(w[35:32]) + 10 * int'(w[42:40]));
    r.seconds    = 7'(int'(w[19:16]) + 10 * int'(w[26:24]));
    r.frames     = 6'(fr);
    r.drop_frame = w[10];
    if (frame_high == FRAMES_24) begin
      f0 = w[27];
      f2 = w[43];
    end else begin
      f0 = w[43];
      f2 = w[59];
    end
    r.user_mode = {f2, f0};
    if (fr == 0 && frame_last != 6'd0) frame_high = frame_last;
    frame_last   = fr[5:0];
    r.frame_rate = frame_high + 6'd1;
    if (!f0) begin
      if (date_sel == DATE_AUTO) begin
        lay = LAYOUT_BBC;
        if (!user_date(w, lay, yy, mo, dd, tz)) begin
          lay = LAYOUT_TVE;
          if (!user_date(w, lay, yy, mo, dd, tz)) begin
            lay = LAYOUT_MTD;
            void'(user_date(w, lay, yy, mo, dd, tz));
          end
        end
      end else begin
        lay = layout_e'(date_sel);
        void'(user_date(w, lay, yy, mo, dd, tz));
      end
      r.date_format = lay;
      r.year        = (yy < YEAR_PIVOT) ? 12'(CENTURY_20XX + yy) : 12'(CENTURY_19XX + yy);
      r.month       = 8'(mo);
      r.day         = 8'(dd);
      r.tz_hours    = 2'(tz);
    end
    return r;
  endfunction

  function automatic logic [63:0] with_nib(input logic [63:0] w, input int grp, input int v);
    w[8 * grp - 4 +: 4] = v[3:0];
    return w;
  endfunction

  function automatic logic [63:0] with_date(input logic [63:0] w, input layout_e lay,
                                            input int yy, input int mo, input int dd);
    case (lay)
      LAYOUT_BBC: begin
        w = with_nib(w, 6, yy % 10);
        w = with_nib(w, 8, yy / 10);
        w = with_nib(w, 3, mo % 10);
        w = with_nib(w, 2, dd % 10);
        w[30:28] = {mo >= 10, 2'(dd / 10)};
      end
      LAYOUT_TVE: begin
        w = with_nib(w, 6, yy % 10);
        w = with_nib(w, 7, yy / 10);
        w = with_nib(w, 4, mo % 10);
        w = with_nib(w, 5, mo / 10);
        w = with_nib(w, 2, dd % 10);
        w = with_nib(w, 3, dd / 10);
      end
      default: begin
        w = with_nib(w, 2, yy % 10);
        w = with_nib(w, 1, yy / 10);
        w = with_nib(w, 4, mo % 10);
        w = with_nib(w, 3, mo / 10);
        w = with_nib(w, 6, dd % 10);
        w = with_nib(w, 5, dd / 10);
      end
    endcase
    return w;
  endfunction

  // BCD time of day, given frame number, random user bits; flags lean towards date modes
  function automatic logic [63:0] timecode(input int fr);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[3:0]   = 4'(fr % 10);
    w[9:8]   = 2'(fr / 10);
    w[19:16] = 4'($urandom_range(0, 9));
    w[26:24] = 3'($urandom_range(0, 5));
    w[35:32] = 4'($urandom_range(0, 9));
    w[42:40] = 3'($urandom_range(0, 5));
    w[51:48] = 4'($urandom_range(0, 9));
    w[57:56] = 2'($urandom_range(0, 2));
    w[27]    = ($urandom_range(0, 3) == 0);
    w[43]    = ($urandom_range(0, 3) == 0);
    w[59]    = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  task automatic queue_random(input int n);
    int made, fr, rate, yy, mo, dd;
    logic [63:0] w;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 3) == 0) begin
        frame_queue.push_back({$urandom, $urandom});
        made++;
      end else begin
        case ($urandom_range(0, 4))
          0: rate = 24;
          1: rate = 25;
          2: rate = 30;
          default: rate = $urandom_range(2, 40);
        endcase
        fr = $urandom_range(0, rate - 1);
        repeat ($urandom_range(5, 45)) begin
          if (made >= n) break;
          w = timecode(fr);
          if ($urandom_range(0, 3) != 0) begin
            yy = $urandom_range(0, 99);
            mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
            dd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 39) : $urandom_range(1, 31);
            w  = with_date(w, layout_e'($urandom_range(1, 3)), yy, mo, dd);
          end
          frame_queue.push_back(w);
          made++;
          fr = (fr + 1) % rate;
        end
      end
    end
  endtask

  task automatic write_date_mode(input logic [1:0] m);
    @(posedge clk_i);
    date_mode_we_i <= 1'b1;
    date_mode_i    <= m;
    @(posedge clk_i);
    date_mode_we_i <= 1'b0;
    date_sel = m;
    mode_writes++;
  endtask

  task automatic drain();
    while (frame_queue.size() != 0 || frame_ch.valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [11:0] got,
                             input logic [11:0] exp_val);
    if (got !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
      errors++;
    end
  endtask

  // frame request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ch.valid      <= 1'b0;
      frame_ch.frame_word <= '0;
      gap_left = 0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        pending_results.push_back(decode_frame(frame_ch.frame_word));
        frames_sent++;
      end
      if (!frame_ch.valid || frame_ch.ready) begin
        if (gap_left > 0) begin
          frame_ch.valid <= 1'b0;
          gap_left--;
        end else if (frame_queue.size() != 0) begin
          frame_ch.valid      <= 1'b1;
          frame_ch.frame_word <= frame_queue.pop_front();
          gap_left = idle_len();
        end else begin
          frame_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, nothing outstanding", $time);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("hours", 12'(result_ch.hours), 12'(want.hours));
          check_field("minutes", 12'(result_ch.minutes), 12'(want.minutes));
          check_field("seconds", 12'(result_ch.seconds), 12'(want.seconds));
          check_field("frames", 12'(result_ch.frames), 12'(want.frames));
          check_field("drop_frame", 12'(result_ch.drop_frame), 12'(want.drop_frame));
          check_field("frame_rate", 12'(result_ch.frame_rate), 12'(want.frame_rate));
          check_field("user_mode", 12'(result_ch.user_mode), 12'(want.user_mode));
          check_field("date_format", 12'(result_ch.date_format), 12'(want.date_format));
          check_field("year", result_ch.year, want.year);
          check_field("month", 12'(result_ch.month), 12'(want.month));
          check_field("day", 12'(result_ch.day), 12'(want.day));
          check_field("tz_hours", 12'(result_ch.tz_hours), 12'(want.tz_hours));
        end
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] w;
    rst_ni              = 1'b0;
    date_mode_we_i      = 1'b0;
    date_mode_i         = DATE_AUTO;
    frame_ch.valid      = 1'b0;
    frame_ch.frame_word = '0;
    result_ch.ready     = 1'b0;
    frame_last          = '0;
    frame_high          = '0;
    date_sel            = DATE_AUTO;
    calm                = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_date_mode(DATE_AUTO);

    frame_queue.push_back('0);
    frame_queue.push_back('1);
    w = timecode(1);
    w[43] = 1'b1; w[59] = 1'b0; w[10] = 1'b1;
    frame_queue.push_back(w);
    w = with_date(timecode(2), LAYOUT_BBC, 66, 12, 31);
    w[43] = 1'b0; w[59] = 1'b0;
    frame_queue.push_back(w);
    // BBC month reads zero, so auto falls through to TVE
    w = with_date(timecode(3), LAYOUT_TVE, 67, 3, 5);
    w[43] = 1'b0; w[59] = 1'b1;
    frame_queue.push_back(w);
    w = with_nib(with_date(timecode(4), LAYOUT_MTD, 0, 1, 20), 7, 3);
    w[43] = 1'b0; w[59] = 1'b0;
    frame_queue.push_back(w);
    w = with_nib(with_date(timecode(5), LAYOUT_MTD, 90, 1, 31), 7, 4'hE);
    w[43] = 1'b0; w[59] = 1'b0;
    frame_queue.push_back(w);
    // no layout valid
    w = timecode(6) | 64'hF0F0_F0F0_F0F0_F0F0;
    w[43] = 1'b0; w[59] = 1'b0;
    frame_queue.push_back(w);
    // wrap after 24, then flags move
    frame_queue.push_back(timecode(24));
    frame_queue.push_back(timecode(0));
    w = timecode(7);
    w[27] = 1'b1; w[43] = 1'b0; w[59] = 1'b1;
    frame_queue.push_back(w);
    frame_queue.push_back(timecode(0));
    frame_queue.push_back(timecode(0));
    w = timecode(0);
    w[3:0] = 4'hF; w[9:8] = 2'd3;
    frame_queue.push_back(w);
    frame_queue.push_back(timecode(0));
    drain();

    for (int p = 7; p >= 0; p--) begin
      write_date_mode(MODE_PLAN[2 * p +: 2]);
      calm = (p % 3 == 1);
      queue_random(PHASE_FRAMES);
      drain();
    end

    $display("Checked %0d of %0d LTC frames over %0d date mode writes,", results_seen,
             frames_sent, mode_writes);
    $display("including frame-rate wraps, all user-bit modes and non-BCD digits.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
